/* hw/rtl/tlpg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpg_pkg
// Shared constants, types and entry helpers for the page table grower.
// ----------------------------------------------------------------------------
package tlpg_pkg;

   localparam int NUM_PAGES         = 64;
   localparam int ENTRIES_PER_TABLE = 1024;
   localparam int PAGE_W            = $clog2(NUM_PAGES);
   localparam int ENTRY_W           = $clog2(ENTRIES_PER_TABLE);
   localparam int ADDR_W            = PAGE_W + ENTRY_W;
   localparam int COUNT_W           = $clog2(NUM_PAGES + 1);
   localparam int WORD_W            = 32;
   localparam int PAGE_SHIFT        = 12;

   localparam logic [1:0] REQ_CREATE = 2'd0;
   localparam logic [1:0] REQ_GROW   = 2'd1;
   localparam logic [1:0] REQ_SHRINK = 2'd2;
   localparam logic [1:0] REQ_FREE   = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_PAGE   = 2'd1;
   localparam logic [1:0] ST_ROOT_FULL = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   typedef struct packed {
      logic [1:0] req_type;
      logic [5:0] root_page;
   } req_payload_type;

   typedef struct packed {
      logic [5:0] page_number;
      logic [1:0] status;
   } rsp_payload_type;

   function automatic logic [WORD_W-1:0] make_entry(input logic [PAGE_W-1:0] page);
      logic [WORD_W-1:0] e;
      e = '0;
      e[PAGE_SHIFT +: PAGE_W] = page;
      e[2:0] = 3'b111;
      return e;
   endfunction

   function automatic logic [PAGE_W-1:0] entry_page(input logic [WORD_W-1:0] e);
      return e[PAGE_SHIFT +: PAGE_W];
   endfunction

endpackage

/* hw/rtl/tlpg_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpg_req_if
// Request channel: valid, ready and request payload.
// ----------------------------------------------------------------------------
interface tlpg_req_if;
   logic                     valid;
   logic                     ready;
   tlpg_pkg::req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/tlpg_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpg_rsp_if
// Response channel: valid, ready and response payload.
// ----------------------------------------------------------------------------
interface tlpg_rsp_if;
   logic                     valid;
   logic                     ready;
   tlpg_pkg::rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/tlpg_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpg_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module tlpg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

/* hw/rtl/two_level_page_table_grower_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_table_grower_unit
// Free page map, free count and two-level page tables in one word RAM.
// ----------------------------------------------------------------------------
// channel  direction  fields
// req      in         req_type, root_page
// rsp      out        page_number, status
//
// One request at a time. A zeroing pass writes one RAM word per cycle through
// the single RAM port; a table scan steps one word at a time, each read taking
// an address state and then a data state. The largest request scans two tables
// of 1024 words and zeroes a new one. The free map scan is one page per cycle.
// Reset marks all pages free; no clearing pass. A waiting response holds the
// block until taken.
// ----------------------------------------------------------------------------
module two_level_page_table_grower_unit (
   input logic    clock,
   input logic    reset,
   tlpg_req_if.sink   req,
   tlpg_rsp_if.source rsp
);
   import tlpg_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_ALLOC, S_ZERO, S_SCAN_A, S_SCAN_D, S_LAST_A, S_LAST_D,
      S_SUB_A, S_SUB_D, S_DECIDE, S_LINK, S_WRITE, S_SHR_A, S_SHR_D,
      S_SHR_CLR, S_SHR_ROOT, S_FREE, S_RESP
   } state_type;

   // allocation purposes
   typedef enum logic [1:0] {
      P_ROOT, P_TABLE, P_DATA
   } purpose_type;

   state_type        state_ff, state_in;
   purpose_type      purp_ff, purp_in;
   logic [NUM_PAGES-1:0] free_ff, free_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [1:0]       op_ff, op_in;
   logic [PAGE_W-1:0] root_ff, root_in;
   logic [PAGE_W-1:0] tbl_ff, tbl_in;      // second-level table
   logic [PAGE_W-1:0] scan_ff, scan_in;    // page being scanned
   logic [PAGE_W-1:0] newp_ff, newp_in;    // page found by free scan
   logic [ENTRY_W:0]  idx_ff, idx_in;
   logic [ENTRY_W:0]  rootf_ff, rootf_in;  // first absent in root
   logic [ENTRY_W:0]  sub_ff, sub_in;      // first absent in table
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [1:0]        stat_ff, stat_in;
   logic              newt_ff, newt_in;
   logic              scanroot_ff, scanroot_in;

   logic              wr_en;
   logic [ADDR_W-1:0] addr;
   logic [WORD_W-1:0] wr_data, rd_data;

   tlpg_ram #(.WIDTH(WORD_W), .DEPTH(NUM_PAGES * ENTRIES_PER_TABLE)) u_ram (
      .clock(clock), .wr_en(wr_en), .addr(addr), .wr_data(wr_data), .rd_data(rd_data)
   );

   localparam logic [ENTRY_W:0] FULL = ENTRY_W'(ENTRIES_PER_TABLE - 1) + (ENTRY_W+1)'(1);

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_RESP);
   assign rsp.payload.page_number = page_ff;
   assign rsp.payload.status      = stat_ff;

   always_comb begin
      state_in = state_ff; purp_in = purp_ff; free_in = free_ff; count_in = count_ff;
      op_in = op_ff; root_in = root_ff; tbl_in = tbl_ff; scan_in = scan_ff;
      newp_in = newp_ff; idx_in = idx_ff; rootf_in = rootf_ff; sub_in = sub_ff;
      page_in = page_ff; stat_in = stat_ff; newt_in = newt_ff; scanroot_in = scanroot_ff;
      wr_en = 1'b0; addr = {scan_ff, idx_ff[ENTRY_W-1:0]}; wr_data = '0;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               op_in = req.payload.req_type;
               root_in = req.payload.root_page[PAGE_W-1:0];
               page_in = '0; stat_in = ST_OK; idx_in = '0; newp_in = '0;
               if (req.payload.req_type == REQ_CREATE) begin
                  if (count_ff == '0) begin
                     stat_in = ST_NO_PAGE; state_in = S_RESP;
                  end else begin
                     purp_in = P_ROOT; state_in = S_ALLOC;
                  end
               end else if (req.payload.req_type == REQ_FREE) begin
                  state_in = S_FREE;
               end else begin
                  scan_in = req.payload.root_page[PAGE_W-1:0];
                  scanroot_in = 1'b1; state_in = S_SCAN_A;
               end
            end
         end
         S_ALLOC: begin
            if (free_ff[newp_ff]) begin
               free_in[newp_ff] = 1'b0;
               count_in = count_ff - COUNT_W'(1);
               idx_in = '0;
               case (purp_ff)
                  P_ROOT: begin
                     page_in = newp_ff; scan_in = newp_ff; state_in = S_ZERO;
                  end
                  P_TABLE: begin
                     tbl_in = newp_ff; scan_in = newp_ff; state_in = S_ZERO;
                  end
                  default: begin
                     page_in = newp_ff; state_in = S_WRITE;
                  end
               endcase
            end else begin
               newp_in = newp_ff + PAGE_W'(1);
            end
         end
         S_ZERO: begin
            wr_en = 1'b1;
            if (idx_ff == (ENTRY_W+1)'(ENTRIES_PER_TABLE - 1)) begin
               state_in = (purp_ff == P_ROOT) ? S_RESP : S_LINK;
            end
            idx_in = idx_ff + (ENTRY_W+1)'(1);
         end
         S_SCAN_A: state_in = S_SCAN_D;
         S_SCAN_D: begin
            if (!rd_data[0] || idx_ff == (ENTRY_W+1)'(ENTRIES_PER_TABLE - 1)) begin
               sub_in = rd_data[0] ? FULL : idx_ff;
               if (scanroot_ff) begin
                  rootf_in = rd_data[0] ? FULL : idx_ff;
                  if (!rd_data[0] && idx_ff == '0) begin
                     if (op_ff == REQ_SHRINK) begin
                        stat_in = ST_EMPTY; state_in = S_RESP;
                     end else begin
                        newt_in = 1'b1; state_in = S_DECIDE;
                     end
                  end else begin
                     idx_in = (rd_data[0] ? FULL : idx_ff) - (ENTRY_W+1)'(1);
                     state_in = S_LAST_A;
                  end
               end else begin
                  state_in = S_SUB_D;
               end
            end else begin
               idx_in = idx_ff + (ENTRY_W+1)'(1);
               state_in = S_SCAN_A;
            end
         end
         S_LAST_A: state_in = S_LAST_D;
         S_LAST_D: begin
            tbl_in = entry_page(rd_data);
            scan_in = entry_page(rd_data);
            scanroot_in = 1'b0; idx_in = '0; state_in = S_SCAN_A;
         end
         S_SUB_D: begin
            if (op_ff == REQ_SHRINK) begin
               if (sub_ff == '0) begin
                  stat_in = ST_EMPTY; state_in = S_RESP;
               end else begin
                  idx_in = sub_ff - (ENTRY_W+1)'(1);
                  state_in = S_SHR_A;
               end
            end else begin
               newt_in = (sub_ff == FULL);
               if (sub_ff == FULL && rootf_ff == FULL) begin
                  stat_in = ST_ROOT_FULL; state_in = S_RESP;
               end else begin
                  state_in = S_DECIDE;
               end
            end
         end
         S_SUB_A: state_in = S_SUB_D;
         S_DECIDE: begin
            if (count_ff < (newt_ff ? COUNT_W'(2) : COUNT_W'(1))) begin
               stat_in = ST_NO_PAGE; state_in = S_RESP;
            end else begin
               newp_in = '0;
               purp_in = newt_ff ? P_TABLE : P_DATA;
               if (newt_ff) sub_in = '0;
               state_in = S_ALLOC;
            end
         end
         S_LINK: begin
            wr_en = 1'b1;
            addr = {root_ff, rootf_ff[ENTRY_W-1:0]};
            wr_data = make_entry(tbl_ff);
            newp_in = '0; purp_in = P_DATA; state_in = S_ALLOC;
         end
         S_WRITE: begin
            wr_en = 1'b1;
            addr = {tbl_ff, sub_ff[ENTRY_W-1:0]};
            wr_data = make_entry(page_ff);
            state_in = S_RESP;
         end
         S_SHR_A: begin
            addr = {tbl_ff, idx_ff[ENTRY_W-1:0]};
            state_in = S_SHR_D;
         end
         S_SHR_D: begin
            addr = {tbl_ff, idx_ff[ENTRY_W-1:0]};
            page_in = entry_page(rd_data);
            if (!free_ff[entry_page(rd_data)]) begin
               free_in[entry_page(rd_data)] = 1'b1;
               count_in = count_ff + COUNT_W'(1);
            end
            state_in = S_SHR_CLR;
         end
         S_SHR_CLR: begin
            wr_en = 1'b1;
            addr = {tbl_ff, idx_ff[ENTRY_W-1:0]};
            if (sub_ff == (ENTRY_W+1)'(1)) begin
               if (!free_ff[tbl_ff]) begin
                  free_in[tbl_ff] = 1'b1;
                  count_in = count_ff + COUNT_W'(1);
               end
               state_in = S_SHR_ROOT;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SHR_ROOT: begin
            wr_en = 1'b1;
            addr = {root_ff, rootf_ff[ENTRY_W-1:0] - ENTRY_W'(1)};
            state_in = S_RESP;
         end
         S_FREE: begin
            wr_en = 1'b1;
            addr = {root_ff, ENTRY_W'(0)};
            if (!free_ff[root_ff]) begin
               free_in[root_ff] = 1'b1;
               count_in = count_ff + COUNT_W'(1);
            end
            page_in = root_ff;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (state_in == S_RESP && stat_in != ST_OK) page_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         free_ff  <= '1;
         count_ff <= COUNT_W'(NUM_PAGES);
      end else begin
         state_ff <= state_in;
         free_ff  <= free_in;
         count_ff <= count_in;
      end
      purp_ff <= purp_in; op_ff <= op_in; root_ff <= root_in; tbl_ff <= tbl_in;
      scan_ff <= scan_in; newp_ff <= newp_in; idx_ff <= idx_in; rootf_ff <= rootf_in;
      sub_ff <= sub_in; page_ff <= page_in; stat_ff <= stat_in; newt_ff <= newt_in;
      scanroot_ff <= scanroot_in;
   end

`ifndef SYNTHESIS
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff == COUNT_W'($countones(free_ff)))
      else $error("free count disagrees with map");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
      else $error("response dropped while stalled");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("request taken while response waits");
`endif
endmodule
